@@ hdl/apenc_pkg.sv @@
package apenc_pkg;

   // Field widths and sizes of the per-channel stores.
   localparam int SAMPLE_BITS  = 24;
   localparam int UPSHIFT      = 32 - SAMPLE_BITS;
   localparam int CHAN_W       = 3;
   localparam int MAX_CHANNELS = 8;
   localparam int RING_AW      = 12;
   localparam int RING_DEPTH   = 4096;
   localparam int RING_WORDS   = MAX_CHANNELS * RING_DEPTH;
   localparam int GRAIN_SHIFT  = 10;
   localparam int MIN_DELAY    = 96;
   localparam int POLES        = 7;
   localparam int POLE_AW      = 3;
   localparam int POLE_WORDS   = MAX_CHANNELS * (1 << POLE_AW);
   localparam int PASS_LIMIT   = 42950;

   // Datapath widths: shared multiplier operands and the working sample.
   localparam int MUL_W = 36;
   localparam int X_W   = 40;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_EFFECT_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_RATIO   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EQ_GAIN       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_ALPHA     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_ALPHA    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AMBIENT_GAIN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd6;

   // Odd sine polynomial in Q30, constant term first.
   localparam logic signed [31:0] SIN_C [5] = '{
      32'sd1686629713, -32'sd693598669, 32'sd85569306, -32'sd5026995, 32'sd172272
   };

   // Pink noise filter: pole feedback and input gains in Q30.
   localparam logic signed [31:0] POLE_A [6] = '{
      32'sd1072517758, 32'sd1066569229, 32'sd1040455828,
      32'sd930397291, 32'sd590558003, -32'sd817761773
   };
   localparam logic signed [31:0] POLE_G [6] = '{
      32'sd59611891, 32'sd80612134, 32'sd165197327,
      32'sd333381375, 32'sd572253066, -32'sd18144089
   };
   localparam logic signed [31:0] WHITE_G    = 32'sd575740366;
   localparam logic signed [31:0] B6_G       = 32'sd124474595;
   localparam logic signed [31:0] PINK_SCALE = 32'sd118111601;

   // Noise generator seed after reset for one channel.
   function automatic logic [31:0] seed_init(input logic [CHAN_W-1:0] c);
      seed_init = 32'h0123_4567 + {29'b0, c} * 32'h9e37_79b9;
   endfunction

endpackage

@@ hdl/audio_pitch_eq_noise_chain.sv @@
// Channel   Direction  Transfer when          Content
// req_      in         req_tvalid&req_tready  tdata sample_in, tuser chan, tlast frame_end
// rsp_      out        rsp_tvalid&rsp_tready  tdata sample_out, tlast out_frame_end
// csr_      in         csr_valid&csr_ready    csr_index register, csr_data value
//
// With effects on, a single 36x36 multiplier serves every product one step
// at a time, and the window division runs one quotient bit per cycle.
// The input is not ready until the result is in the output register; that
// register holds one finished sample while the next is taken in.
// Reset is synchronous; the history ring is not cleared.
module audio_pitch_eq_noise_chain (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] sample_in
   input  logic [2:0]  req_tuser,   // [2:0] chan
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] sample_out
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_W0, S_W1, S_W2, S_W3, S_T0, S_T1, S_T2, S_T3, S_T4,
      S_D0, S_DIV, S_DF, S_E0, S_E1, S_E2, S_E3,
      S_N0, S_N1, S_N2, S_N3, S_N4, S_N5, S_N6, S_N7, S_N8, S_FIN, S_OUT
   } state_type;

   localparam int MW = apenc_pkg::MUL_W;
   localparam int XW = apenc_pkg::X_W;
   localparam int CW = apenc_pkg::CHAN_W;
   localparam int AW = apenc_pkg::RING_AW;
   localparam int PW = apenc_pkg::POLE_AW;
   localparam int GS = apenc_pkg::GRAIN_SHIFT;

   function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
      if (v > 40'sd2147483647) sat32 = 32'sh7fff_ffff;
      else if (v < -40'sd2147483648) sat32 = 32'sh8000_0000;
      else sat32 = v[31:0];
   endfunction

   function automatic logic signed [31:0] clamp_q30(input logic signed [XW-1:0] v);
      if (v > 40'sd1073741824) clamp_q30 = 32'sd1073741824;
      else if (v < -40'sd1073741824) clamp_q30 = -32'sd1073741824;
      else clamp_q30 = v[31:0];
   endfunction

   state_type state_ff, state_in;

   // Configuration registers.
   logic [2:0]         mode_ff, mode_in;
   logic signed [31:0] ratio_ff, ratio_in;
   logic signed [23:0] eqg_ff, eqg_in;
   logic [31:0]        lalpha_ff, lalpha_in, halpha_ff, halpha_in, amb_ff, amb_in;
   logic [3:0]         chcnt_ff, chcnt_in;

   // Shared state advanced at frame end.
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW:0]   fill_ff, fill_in;
   logic [31:0]   phase_ff, phase_in;

   // Per-channel filter and noise state.
   logic signed [31:0] lo_ff [apenc_pkg::MAX_CHANNELS];
   logic signed [31:0] lo_in [apenc_pkg::MAX_CHANNELS];
   logic signed [31:0] hi_ff [apenc_pkg::MAX_CHANNELS];
   logic signed [31:0] hi_in [apenc_pkg::MAX_CHANNELS];
   logic [31:0]        seed_ff [apenc_pkg::MAX_CHANNELS];
   logic [31:0]        seed_in [apenc_pkg::MAX_CHANNELS];

   // Working registers of the sequencer.
   logic [CW-1:0]        chan_ff, chan_in;
   logic                 fe_ff, fe_in;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [MW-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic                 win_ff, win_in;
   logic [2:0]           k_ff, k_in;
   logic [30:0]          z_ff, z_in, z2_ff, z2_in, ga_ff, ga_in, gb_ff, gb_in;
   logic signed [23:0]   s0_ff, s0_in;
   logic [31:0]          frac_ff, frac_in;
   logic [AW-1:0]        i0_ff, i0_in;
   logic signed [63:0]   num_ff, num_in;
   logic [31:0]          rem_ff, rem_in, q_ff, q_in, den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [4:0]           dcnt_ff, dcnt_in;
   logic signed [31:0]   lo_new_ff, lo_new_in, white_ff, white_in, t1_ff, t1_in;
   logic signed [MW-1:0] sum_ff, sum_in;
   logic [23:0]          rsp_tdata_ff, rsp_tdata_in;
   logic                 rsp_tlast_ff, rsp_tlast_in, rsp_tvalid_ff, rsp_tvalid_in;

   // History ring memory.
   logic [23:0]            ring_mem [apenc_pkg::RING_WORDS];
   logic                   ring_we;
   logic [CW+AW-1:0]       ring_waddr, ring_raddr;
   logic signed [23:0]     ring_rd_ff;

   // Pink pole memory with valid bits.
   logic [31:0]            pp_mem [apenc_pkg::POLE_WORDS];
   logic [apenc_pkg::POLE_WORDS-1:0] pp_valid_ff, pp_valid_in;
   logic                   pp_we;
   logic [CW+PW-1:0]       pp_waddr, pp_raddr;
   logic signed [31:0]     pp_wdata, pp_rd_ff, pole_b;
   logic                   pp_rdv_ff;

   // Shared multiplier and its shifted views.
   logic signed [2*MW-1:0] prod, p23, p24, p25, p30, p32, p37;
   assign prod = ma_ff * mb_ff;
   assign p23  = prod >>> 23;
   assign p24  = prod >>> 24;
   assign p25  = prod >>> 25;
   assign p30  = prod >>> 30;
   assign p32  = prod >>> 32;
   assign p37  = prod >>> 37;

   // Grain phase, sine window argument and tap position.
   logic [31:0]     ph_sel;
   logic [32:0]     ph_rev, term;
   logic [30:0]     z_val;
   logic            ratio_up, borrow;
   logic [32:0]     ratio_abs;
   logic [31:0]     frac_f, frac_val;
   logic [AW-1:0]   tap_ip, tap_i0;
   logic            pitch_on, proc;

   assign ph_sel    = win_ff ? phase_ff + 32'h8000_0000 : phase_ff;
   assign ph_rev    = 33'h1_0000_0000 - {1'b0, ph_sel};
   assign z_val     = ph_sel[31] ? ph_rev[31:1] : ph_sel[31:1];
   assign ratio_up  = !ratio_ff[31] && (ratio_ff != 32'sd0);
   assign ratio_abs = ratio_ff[31] ? 33'd0 - {ratio_ff[31], ratio_ff} : {1'b0, ratio_ff};
   assign term      = ratio_up ? ph_rev : {1'b0, ph_sel};
   assign borrow    = |term[31-GS:0];
   assign frac_f    = {term[31-GS:0], {GS{1'b0}}};
   assign frac_val  = borrow ? 32'(33'h1_0000_0000 - {1'b0, frac_f}) : 32'd0;
   assign tap_ip    = AW'(apenc_pkg::MIN_DELAY) + AW'(term[32:32-GS]);
   assign tap_i0    = wp_ff - tap_ip - {{(AW-1){1'b0}}, borrow};
   assign pitch_on  = mode_ff[0] && (fill_ff >= (AW+1)'(apenc_pkg::RING_DEPTH)) &&
                      (ratio_abs >= 33'(apenc_pkg::PASS_LIMIT));
   assign proc      = {1'b0, req_tuser} < chcnt_ff;
   assign pole_b    = pp_rdv_ff ? pp_rd_ff : 32'sd0;

   // Band filter updates, window clamp, noise source and output saturation.
   logic signed [31:0]   lo_upd, hi_upd, nb, seed_cur, xs1, xs2, xs3;
   logic signed [41:0]   w_full;
   logic [30:0]          w_val;
   logic [32:0]          r2;
   logic                 r2_ge;
   logic signed [XW-1:0] y_full, q_ext;
   logic [23:0]          y_sat;

   assign lo_upd   = sat32(XW'(lo_ff[chan_ff]) + XW'(p32));
   assign hi_upd   = sat32(XW'(hi_ff[chan_ff]) + XW'(p32));
   assign nb       = clamp_q30(XW'(t1_ff) + XW'(p37));
   assign w_full   = 42'(p30);
   assign w_val    = (w_full < 42'sd0) ? 31'd0 :
                     (w_full > 42'sd1073741824) ? 31'd1073741824 : w_full[30:0];
   assign seed_cur = seed_ff[chan_ff];
   assign xs1      = seed_cur ^ (seed_cur << 13);
   assign xs2      = xs1 ^ (xs1 >> 17);
   assign xs3      = xs2 ^ (xs2 << 5);
   assign r2       = {rem_ff, q_ff[31]};
   assign r2_ge    = r2 >= {1'b0, den_ff};
   assign q_ext    = $signed({{(XW-32){1'b0}}, q_ff});
   assign y_full   = x_ff >>> apenc_pkg::UPSHIFT;
   assign y_sat    = (y_full > 40'sd8388607) ? 24'h7f_ffff :
                     (y_full < -40'sd8388608) ? 24'h80_0000 : y_full[23:0];

   // Next stage once the pitch shifter is done or skipped.
   state_type after_pitch, after_eq;
   assign after_eq    = mode_ff[2] ? S_N0 : S_FIN;
   assign after_pitch = mode_ff[1] ? S_E0 : after_eq;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // Sequencer: one multiply or one division step per cycle.
   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff; ratio_in = ratio_ff; eqg_in = eqg_ff;
      lalpha_in = lalpha_ff; halpha_in = halpha_ff; amb_in = amb_ff; chcnt_in = chcnt_ff;
      wp_in = wp_ff; fill_in = fill_ff; phase_in = phase_ff;
      lo_in = lo_ff; hi_in = hi_ff; seed_in = seed_ff;
      chan_in = chan_ff; fe_in = fe_ff; x_in = x_ff;
      ma_in = ma_ff; mb_in = mb_ff; win_in = win_ff; k_in = k_ff;
      z_in = z_ff; z2_in = z2_ff; ga_in = ga_ff; gb_in = gb_ff;
      s0_in = s0_ff; frac_in = frac_ff; i0_in = i0_ff; num_in = num_ff;
      rem_in = rem_ff; q_in = q_ff; den_in = den_ff; neg_in = neg_ff; dcnt_in = dcnt_ff;
      lo_new_in = lo_new_ff; white_in = white_ff; t1_in = t1_ff; sum_in = sum_ff;
      rsp_tdata_in = rsp_tdata_ff; rsp_tlast_in = rsp_tlast_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      pp_valid_in = pp_valid_ff;
      ring_we = 1'b0; ring_waddr = {req_tuser, wp_ff}; ring_raddr = {chan_ff, tap_i0};
      pp_we = 1'b0; pp_waddr = {chan_ff, k_ff}; pp_wdata = nb; pp_raddr = {chan_ff, k_ff};

      // Configuration writes.
      if (csr_valid) begin
         unique case (csr_index)
            apenc_pkg::REG_EFFECT_MODE:   mode_in   = csr_data[2:0];
            apenc_pkg::REG_PITCH_RATIO:   ratio_in  = csr_data;
            apenc_pkg::REG_EQ_GAIN:       eqg_in    = csr_data[23:0];
            apenc_pkg::REG_LOW_ALPHA:     lalpha_in = csr_data;
            apenc_pkg::REG_HIGH_ALPHA:    halpha_in = csr_data;
            apenc_pkg::REG_AMBIENT_GAIN:  amb_in    = csr_data;
            apenc_pkg::REG_CHANNEL_COUNT: chcnt_in  = csr_data[3:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // Take a sample and, for a processed channel, store it in its channel's ring.
         S_IDLE: begin
            if (req_tvalid) begin
               chan_in = req_tuser;
               fe_in   = req_tlast;
               x_in    = XW'($signed(req_tdata)) <<< apenc_pkg::UPSHIFT;
               win_in  = 1'b0;
               ring_we = proc;
               if (!proc) state_in = S_FIN;
               else if (pitch_on) state_in = S_W0;
               else state_in = after_pitch;
            end
         end
         // Sine windows of the two grains, one after the other.
         S_W0: begin
            z_in = z_val;
            ma_in = MW'(z_val);
            mb_in = MW'(z_val);
            state_in = S_W1;
         end
         S_W1: begin
            z2_in = prod[60:30];
            ma_in = MW'(apenc_pkg::SIN_C[4]);
            mb_in = MW'(prod[60:30]);
            k_in = 3'd3;
            state_in = S_W2;
         end
         S_W2: begin
            ma_in = MW'(apenc_pkg::SIN_C[k_ff]) + MW'(p30);
            if (k_ff == 3'd0) begin
               mb_in = MW'(z_ff);
               state_in = S_W3;
            end else begin
               mb_in = MW'(z2_ff);
               k_in = k_ff - 3'd1;
            end
         end
         S_W3: begin
            if (!win_ff) begin
               ga_in = w_val;
               win_in = 1'b1;
               state_in = S_W0;
            end else begin
               gb_in = w_val;
               win_in = 1'b0;
               state_in = S_T0;
            end
         end
         // Interpolated tap: read both neighbors, then weight by the window.
         S_T0: begin
            i0_in = tap_i0;
            frac_in = frac_val;
            state_in = S_T1;
         end
         S_T1: begin
            ring_raddr = {chan_ff, i0_ff + AW'(1)};
            s0_in = ring_rd_ff;
            state_in = S_T2;
         end
         S_T2: begin
            ma_in = MW'(ring_rd_ff) - MW'(s0_ff);
            mb_in = MW'(frac_ff);
            state_in = S_T3;
         end
         S_T3: begin
            ma_in = (MW'(s0_ff) <<< apenc_pkg::UPSHIFT) + MW'(p24);
            mb_in = MW'(win_ff ? gb_ff : ga_ff);
            state_in = S_T4;
         end
         S_T4: begin
            num_in = (win_ff ? num_ff : 64'sd0) + 64'(prod);
            if (!win_ff) begin
               win_in = 1'b1;
               state_in = S_T0;
            end else begin
               state_in = S_D0;
            end
         end
         // Floor division of the weighted sum by the window sum.
         S_D0: begin
            den_in = {1'b0, ga_ff} + {1'b0, gb_ff};
            neg_in = num_ff[63];
            {rem_in, q_in} = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
            dcnt_in = 5'd31;
            if (ga_ff == 31'd0 && gb_ff == 31'd0) state_in = after_pitch;
            else state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = r2_ge ? 32'(r2 - {1'b0, den_ff}) : r2[31:0];
            q_in = {q_ff[30:0], r2_ge};
            if (dcnt_ff == 5'd0) state_in = S_DF;
            else dcnt_in = dcnt_ff - 5'd1;
         end
         S_DF: begin
            x_in = neg_ff ? -q_ext - XW'(rem_ff != 32'd0) : q_ext;
            state_in = after_pitch;
         end
         // Low band plus high band boost.
         S_E0: begin
            ma_in = MW'(x_ff) - MW'(lo_ff[chan_ff]);
            mb_in = MW'(lalpha_ff);
            state_in = S_E1;
         end
         S_E1: begin
            lo_new_in = lo_upd;
            lo_in[chan_ff] = lo_upd;
            ma_in = MW'(x_ff) - MW'(hi_ff[chan_ff]);
            mb_in = MW'(halpha_ff);
            state_in = S_E2;
         end
         S_E2: begin
            hi_in[chan_ff] = hi_upd;
            ma_in = MW'(eqg_ff);
            mb_in = MW'(lo_new_ff) + MW'(x_ff) - MW'(hi_upd);
            state_in = S_E3;
         end
         S_E3: begin
            x_in = x_ff + XW'(p23);
            state_in = after_eq;
         end
         // Pink noise: step the generator and run the pole chain.
         S_N0: begin
            seed_in[chan_ff] = xs3;
            white_in = xs3 ^ 32'h8000_0000;
            k_in = 3'd0;
            sum_in = '0;
            pp_raddr = {chan_ff, 3'd0};
            state_in = S_N1;
         end
         S_N1: begin
            ma_in = MW'(apenc_pkg::POLE_A[k_ff]);
            mb_in = MW'(pole_b);
            state_in = S_N2;
         end
         S_N2: begin
            t1_in = p30[31:0];
            ma_in = MW'(apenc_pkg::POLE_G[k_ff]);
            mb_in = MW'(white_ff);
            state_in = S_N3;
         end
         S_N3: begin
            pp_we = 1'b1;
            pp_valid_in[{chan_ff, k_ff}] = 1'b1;
            sum_in = sum_ff + MW'(nb);
            if (k_ff == 3'(apenc_pkg::POLES - 2)) begin
               pp_raddr = {chan_ff, 3'(apenc_pkg::POLES - 1)};
               state_in = S_N4;
            end else begin
               k_in = k_ff + 3'd1;
               pp_raddr = {chan_ff, k_ff + 3'd1};
               state_in = S_N1;
            end
         end
         S_N4: begin
            sum_in = sum_ff + MW'(pole_b);
            ma_in = MW'(apenc_pkg::WHITE_G);
            mb_in = MW'(white_ff);
            state_in = S_N5;
         end
         S_N5: begin
            sum_in = sum_ff + MW'(p37);
            ma_in = MW'(apenc_pkg::B6_G);
            mb_in = MW'(white_ff);
            state_in = S_N6;
         end
         S_N6: begin
            pp_we = 1'b1;
            pp_waddr = {chan_ff, 3'(apenc_pkg::POLES - 1)};
            pp_wdata = p37[31:0];
            pp_valid_in[{chan_ff, 3'(apenc_pkg::POLES - 1)}] = 1'b1;
            ma_in = sum_ff;
            mb_in = MW'(apenc_pkg::PINK_SCALE);
            state_in = S_N7;
         end
         S_N7: begin
            ma_in = MW'(p30);
            mb_in = MW'(amb_ff);
            state_in = S_N8;
         end
         S_N8: begin
            x_in = x_ff + XW'(p25);
            state_in = S_FIN;
         end
         // Advance the shared ring position and grain phase at frame end.
         S_FIN: begin
            if (fe_ff) begin
               wp_in = wp_ff + AW'(1);
               if (fill_ff < (AW+1)'(apenc_pkg::RING_DEPTH)) fill_in = fill_ff + (AW+1)'(1);
               phase_in = phase_ff + 32'(ratio_abs >> GS);
            end
            state_in = S_OUT;
         end
         // Hand the result to the output register once it is free.
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tdata_in = y_sat;
               rsp_tlast_in = fe_ff;
               rsp_tvalid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, configuration and registered outputs.
   always_ff @(posedge clock) begin
      chan_ff <= chan_in; fe_ff <= fe_in; x_ff <= x_in;
      ma_ff <= ma_in; mb_ff <= mb_in;
      z_ff <= z_in; z2_ff <= z2_in; ga_ff <= ga_in; gb_ff <= gb_in;
      s0_ff <= s0_in; frac_ff <= frac_in; i0_ff <= i0_in; num_ff <= num_in;
      rem_ff <= rem_in; q_ff <= q_in; den_ff <= den_in; neg_ff <= neg_in;
      lo_new_ff <= lo_new_in; white_ff <= white_in; t1_ff <= t1_in; sum_ff <= sum_in;
      rsp_tdata_ff <= rsp_tdata_in; rsp_tlast_ff <= rsp_tlast_in;
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= 3'd0;
         ratio_ff <= 32'sd52192737;
         eqg_ff <= 24'sd1033200;
         lalpha_ff <= 32'd33574000;
         halpha_ff <= 32'd3700000000;
         amb_ff <= 32'd2415000;
         chcnt_ff <= 4'd2;
         wp_ff <= '0;
         fill_ff <= '0;
         phase_ff <= '0;
         for (int c = 0; c < apenc_pkg::MAX_CHANNELS; c++) begin
            lo_ff[c] <= '0;
            hi_ff[c] <= '0;
            seed_ff[c] <= apenc_pkg::seed_init(CW'(c));
         end
         win_ff <= 1'b0;
         k_ff <= '0;
         dcnt_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
         pp_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         ratio_ff <= ratio_in;
         eqg_ff <= eqg_in;
         lalpha_ff <= lalpha_in;
         halpha_ff <= halpha_in;
         amb_ff <= amb_in;
         chcnt_ff <= chcnt_in;
         wp_ff <= wp_in;
         fill_ff <= fill_in;
         phase_ff <= phase_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         seed_ff <= seed_in;
         win_ff <= win_in;
         k_ff <= k_in;
         dcnt_ff <= dcnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         pp_valid_ff <= pp_valid_in;
      end
   end

   // History ring: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_waddr] <= req_tdata;
      ring_rd_ff <= ring_mem[ring_raddr];
   end

   // Pink pole store; the valid bit travels with the read data.
   always_ff @(posedge clock) begin
      if (pp_we) pp_mem[pp_waddr] <= pp_wdata;
      pp_rd_ff <= pp_mem[pp_raddr];
      pp_rdv_ff <= pp_valid_ff[pp_raddr];
   end

endmodule

@@ sim/tb_audio_pitch_eq_noise_chain.sv @@
module tb_audio_pitch_eq_noise_chain;
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64_type;

   typedef struct {
      logic [23:0] smp;
      logic        fe;
   } out_type;

   typedef struct {
      bit [2:0]    ch;
      logic [23:0] smp;
      bit          fe;
      logic [23:0] exp_smp;
   } stim_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   audio_pitch_eq_noise_chain u_dut (.*);

   // Shadow copy of the block state and its registers.
   int        ring_mem [apenc_pkg::RING_WORDS];
   int        low_st [apenc_pkg::MAX_CHANNELS];
   int        high_st [apenc_pkg::MAX_CHANNELS];
   bit [31:0] seed_st [apenc_pkg::MAX_CHANNELS];
   int        pole_st [apenc_pkg::MAX_CHANNELS*apenc_pkg::POLES];
   int        wpos, fill;
   bit [31:0] gphase;
   bit [2:0]  cfg_mode;
   bit [31:0] cfg_ratio, cfg_low, cfg_high, cfg_amb;
   bit [23:0] cfg_eq;
   bit [3:0]  cfg_count;

   out_type pending_out [$];
   bit   failed;
   bit   hold_req;

   // Directed samples at the reset settings: no effect is on, so every
   // sample comes back unchanged, processed channel or not.
   stim_type directed [13] = '{
      '{3'd0, 24'h000000, 1'b0, 24'h000000}, '{3'd1, 24'h7fffff, 1'b1, 24'h7fffff},
      '{3'd0, 24'h800000, 1'b0, 24'h800000}, '{3'd1, 24'hffffff, 1'b1, 24'hffffff},
      '{3'd0, 24'h000001, 1'b0, 24'h000001}, '{3'd1, 24'h555555, 1'b1, 24'h555555},
      '{3'd2, 24'haaaaaa, 1'b0, 24'haaaaaa}, '{3'd7, 24'h123456, 1'b1, 24'h123456},
      '{3'd0, 24'h7fffff, 1'b0, 24'h7fffff}, '{3'd1, 24'h800000, 1'b1, 24'h800000},
      '{3'd5, 24'h000000, 1'b1, 24'h000000}, '{3'd3, 24'h7fffff, 1'b0, 24'h7fffff},
      '{3'd6, 24'h800000, 1'b1, 24'h800000}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // floor(d * a / 2^32)
   function automatic longint mulq32(longint d, longint a);
      u64_type p;
      if (d >= 0) begin
         return longint'((u64_type'(d) * u64_type'(a)) >> 32);
      end
      p = u64_type'(-d) * u64_type'(a);
      return -longint'((p >> 32) + u64_type'(p[31:0] != 0));
   endfunction

   function automatic longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if (n % d != 0 && n < 0) begin
         q--;
      end
      return q;
   endfunction

   function automatic longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Sine window over half a turn, Q30.
   function automatic longint sine_window(bit [31:0] ph);
      longint z, z2, acc;
      z = ph < 32'h8000_0000 ? longint'(ph) >>> 1 : (64'sh1_0000_0000 - longint'(ph)) >>> 1;
      z2 = (z * z) >>> 30;
      acc = longint'(apenc_pkg::SIN_C[4]);
      for (int i = 3; i >= 0; i--) begin
         acc = longint'(apenc_pkg::SIN_C[i]) + ((acc * z2) >>> 30);
      end
      return clampl((acc * z) >>> 30, 0, 64'sd1 << 30);
   endfunction

   // Linearly interpolated read of one grain tap, Q31.
   function automatic longint grain_tap(int base, bit up, bit [31:0] ph);
      u64_type dl, frac;
      int   ip, borrow, i0, i1;
      longint s0, s1;
      dl = (u64_type'(apenc_pkg::MIN_DELAY) << 32) +
           u64_type'(1 << apenc_pkg::GRAIN_SHIFT) *
           (up ? (64'h1_0000_0000 - u64_type'(ph)) : u64_type'(ph));
      ip = int'((dl >> 32) % apenc_pkg::RING_DEPTH);
      borrow = (dl[31:0] != 0);
      frac = borrow ? 64'h1_0000_0000 - u64_type'(dl[31:0]) : 0;
      i0 = (wpos + 2 * apenc_pkg::RING_DEPTH - ip - borrow) % apenc_pkg::RING_DEPTH;
      i1 = (i0 + 1) % apenc_pkg::RING_DEPTH;
      s0 = ring_mem[base + i0];
      s1 = ring_mem[base + i1];
      return s0 * 256 + mulq32((s1 - s0) * 256, longint'(frac));
   endfunction

   // One step of the xorshift-fed pink noise filter of a channel.
   function automatic longint pink_noise(int c);
      bit [31:0] s;
      longint white, sum, nb;
      int b;
      b = c * apenc_pkg::POLES;
      s = seed_st[c];
      s ^= s << 13;
      s ^= s >> 17;
      s ^= s << 5;
      seed_st[c] = s;
      white = longint'(s) - 64'sd2147483648;
      sum = 0;
      for (int i = 0; i < 6; i++) begin
         nb = ((longint'(apenc_pkg::POLE_A[i]) * longint'(pole_st[b+i])) >>> 30) +
              ((longint'(apenc_pkg::POLE_G[i]) * white) >>> 37);
         pole_st[b+i] = int'(clampl(nb, -(64'sd1 << 30), 64'sd1 << 30));
         sum += pole_st[b+i];
      end
      sum += longint'(pole_st[b+6]) + ((longint'(apenc_pkg::WHITE_G) * white) >>> 37);
      pole_st[b+6] = int'((longint'(apenc_pkg::B6_G) * white) >>> 37);
      return (sum * longint'(apenc_pkg::PINK_SCALE)) >>> 30;
   endfunction

   // Processed sample for one accepted input, updating the shadow state.
   function automatic logic [23:0] chain_sample(bit [2:0] ch, logic [23:0] smp, bit fe);
      longint s, d, mag, x, y, lo, hi, ga, gb, num, den;
      int base;
      bit [31:0] pa, pb;
      s = longint'($signed(smp));
      d = longint'(int'(cfg_ratio));
      mag = d < 0 ? -d : d;
      y = s;
      if (ch < cfg_count) begin
         base = ch * apenc_pkg::RING_DEPTH;
         x = s * 256;
         ring_mem[base + wpos] = int'(s);
         if (cfg_mode[0] && fill >= apenc_pkg::RING_DEPTH && mag >= apenc_pkg::PASS_LIMIT) begin
            pa = gphase;
            pb = gphase + 32'h8000_0000;
            ga = sine_window(pa);
            gb = sine_window(pb);
            num = grain_tap(base, d > 0, pa) * ga + grain_tap(base, d > 0, pb) * gb;
            den = ga + gb;
            if (den > 0) begin
               x = fdiv(num, den);
            end
         end
         if (cfg_mode[1]) begin
            lo = low_st[ch];
            hi = high_st[ch];
            lo += mulq32(x - lo, longint'(cfg_low));
            hi += mulq32(x - hi, longint'(cfg_high));
            low_st[ch] = int'(clampl(lo, -64'sd2147483648, 64'sd2147483647));
            high_st[ch] = int'(clampl(hi, -64'sd2147483648, 64'sd2147483647));
            x = x + ((longint'($signed(cfg_eq)) *
                      (longint'(low_st[ch]) + (x - longint'(high_st[ch])))) >>> 23);
         end
         if (cfg_mode[2]) begin
            x += (pink_noise(ch) * longint'(cfg_amb)) >>> 25;
         end
         y = clampl(x >>> 8, -64'sd8388608, 64'sd8388607);
      end
      if (fe) begin
         wpos = (wpos + 1) % apenc_pkg::RING_DEPTH;
         if (fill < apenc_pkg::RING_DEPTH) begin
            fill++;
         end
         gphase += 32'(mag / 1024);
      end
      return y[23:0];
   endfunction

   // Register write through the configuration channel, mirrored locally.
   // The caller drops csr_valid after the last write of a sequence.
   task automatic write_reg(logic [apenc_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         apenc_pkg::REG_EFFECT_MODE:   cfg_mode  = val[2:0];
         apenc_pkg::REG_PITCH_RATIO:   cfg_ratio = val;
         apenc_pkg::REG_EQ_GAIN:       cfg_eq    = val[23:0];
         apenc_pkg::REG_LOW_ALPHA:     cfg_low   = val;
         apenc_pkg::REG_HIGH_ALPHA:    cfg_high  = val;
         apenc_pkg::REG_AMBIENT_GAIN:  cfg_amb   = val;
         apenc_pkg::REG_CHANNEL_COUNT: cfg_count = val[3:0];
         default: ;
      endcase
   endtask

   // One sample transfer on the input side, with a random gap before it.
   task automatic send(bit [2:0] ch, logic [23:0] smp, bit fe, bit typed, logic [23:0] tval);
      int   gap;
      out_type e;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) begin
         gap = 0;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tuser  <= ch;
      req_tlast  <= fe;
      do @(posedge clock); while (!req_tready);
      e.smp = chain_sample(ch, smp, fe);
      if (typed) begin
         e.smp = tval;
      end
      e.fe = fe;
      pending_out.push_back(e);
   endtask

   function automatic logic [23:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return 24'h7fffff;
         1: return 24'h800000;
         2: return 24'($urandom_range(0, 15)) - 24'd8;
         default: return 24'($urandom);
      endcase
   endfunction

   // Mostly whole frames over the processed channels, some stray samples.
   task automatic run_frames(int n);
      int sent, k;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(0, 99) < 85) begin
            k = (cfg_count >= 1 && cfg_count <= apenc_pkg::MAX_CHANNELS) ?
                cfg_count : apenc_pkg::MAX_CHANNELS;
            for (int c = 0; c < k; c++) begin
               send(3'(c), rand_sample(), c == k - 1, 1'b0, '0);
            end
            sent += k;
         end else begin
            send(3'($urandom), rand_sample(), 1'($urandom), 1'b0, '0);
            sent++;
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (pending_out.size() == 0);
      repeat (120) @(posedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_req = 1'b0;
         end
         stall = $urandom_range(0, 3);
         if ($urandom_range(0, 3) == 0) begin
            stall = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare every result transfer with the oldest expectation.
   always @(posedge clock) begin
      out_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_out.size() == 0) begin
            $display("%0t: unexpected result sample %h last %b", $time, rsp_tdata, rsp_tlast);
            failed = 1'b1;
         end else begin
            e = pending_out.pop_front();
            if (rsp_tdata !== e.smp) begin
               $display("%0t: sample expected %h actual %h", $time, e.smp, rsp_tdata);
               failed = 1'b1;
            end
            if (rsp_tlast !== e.fe) begin
               $display("%0t: frame end expected %b actual %b", $time, e.fe, rsp_tlast);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      logic [31:0] ph_cfg [7];
      failed = 1'b0;
      hold_req = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      foreach (ring_mem[i]) ring_mem[i] = 0;
      foreach (pole_st[i]) pole_st[i] = 0;
      for (int c = 0; c < apenc_pkg::MAX_CHANNELS; c++) begin
         low_st[c] = 0;
         high_st[c] = 0;
         seed_st[c] = 32'h0123_4567 + 32'(c) * 32'h9e37_79b9;
      end
      wpos = 0;
      fill = 0;
      gphase = '0;
      cfg_mode = 3'd0;
      cfg_ratio = 32'd52192737;
      cfg_eq = 24'd1033200;
      cfg_low = 32'd33574000;
      cfg_high = 32'd3700000000;
      cfg_amb = 32'd2415000;
      cfg_count = 4'd2;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings pass every sample through.
      foreach (directed[i]) begin
         send(directed[i].ch, directed[i].smp, directed[i].fe, 1'b1, directed[i].exp_smp);
      end
      drain();

      // Fill every channel's history so the pitch stage engages.
      write_reg(apenc_pkg::REG_CHANNEL_COUNT, 32'd8);
      csr_valid <= 1'b0;
      for (int f = 0; f < apenc_pkg::RING_DEPTH; f++) begin
         for (int c = 0; c < apenc_pkg::MAX_CHANNELS; c++) begin
            send(3'(c), 24'($urandom), c == apenc_pkg::MAX_CHANNELS - 1, 1'b0, '0);
         end
      end
      drain();

      // Setting phases: mode, ratio, eq gain, low, high, noise gain, count.
      for (int p = 0; p < 11; p++) begin
         for (int r = 0; r < 7; r++) begin
            ph_cfg[r] = $urandom;
         end
         ph_cfg[6] = $urandom_range(1, 8);
         case (p)
            0: ph_cfg = '{32'd7, 32'd52192737, 32'd1033200, 32'd33574000,
                          32'd3700000000, 32'd2415000, 32'd8};
            1: ph_cfg = '{32'd1, 32'h8000_0000, 32'h80_0000, 32'd0, 32'd0, 32'd0, 32'd8};
            2: ph_cfg = '{32'd3, 32'h7fff_ffff, 32'h7f_ffff, 32'hffff_ffff,
                          32'hffff_ffff, 32'hffff_ffff, 32'd4};
            3: begin
               ph_cfg[0] = 32'd1;
               ph_cfg[1] = 32'd42949;
               ph_cfg[6] = 32'd3;
            end
            4: begin
               ph_cfg[0] = 32'd1;
               ph_cfg[1] = -32'sd42950;
            end
            5: begin
               ph_cfg[0] = 32'd7;
               ph_cfg[6] = 32'd15;
            end
            6: begin
               ph_cfg[0] = 32'd6;
               ph_cfg[6] = 32'd0;
            end
            7: ph_cfg[0] = 32'd2;
            8: ph_cfg[0] = 32'd4;
            9: ph_cfg[0] = 32'd5;
            default: begin
               ph_cfg[0] = 32'd7;
               ph_cfg[6] = 32'd1;
            end
         endcase
         write_reg(apenc_pkg::REG_EFFECT_MODE, ph_cfg[0]);
         write_reg(apenc_pkg::REG_PITCH_RATIO, ph_cfg[1]);
         write_reg(apenc_pkg::REG_EQ_GAIN, ph_cfg[2]);
         write_reg(apenc_pkg::REG_LOW_ALPHA, ph_cfg[3]);
         write_reg(apenc_pkg::REG_HIGH_ALPHA, ph_cfg[4]);
         write_reg(apenc_pkg::REG_AMBIENT_GAIN, ph_cfg[5]);
         write_reg(apenc_pkg::REG_CHANNEL_COUNT, ph_cfg[6]);
         csr_valid <= 1'b0;
         if (p == 1) begin
            hold_req = 1'b1;
         end
         run_frames(50);
         drain();
      end

      if (!failed) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
